FILE: design/gnd_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the grid diffusion block
package gnd_pkg;

    // fixed field widths of the command and result beats
    localparam int OP_W      = 2;
    localparam int COORD_W   = 8;
    localparam int VALUE_W   = 16;
    localparam int BLEND_W   = 9;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;

    // blend weight is in 256ths
    localparam int BLEND_SHIFT = 8;

    // command opcodes
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

    // configuration reset values
    localparam logic [CFG_W-1:0] GRID_WIDTH_RESET  = 9'd200;
    localparam logic [CFG_W-1:0] GRID_HEIGHT_RESET = 9'd200;

    // command beat
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [VALUE_W-1:0] value;
        logic [BLEND_W-1:0] blend;
    } item_t;

    // result beat
    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic               step_saturated;
    } result_t;

    // control of the shared neighbour accumulator
    typedef struct packed {
        logic clear;
        logic add;
    } acc_ctl_t;

endpackage

FILE: design/grid_neighbour_diffusion_step.sv
`timescale 1ns / 1ps
// top level: command sequencer, grid memories and configuration registers
//
//  channel   signals                           handshake
//  -------   -------------------------------   ------------------------------
//  command   start, busy, item                 taken when start & !busy
//  result    done, result                      one-cycle strobe, no stall
//  config    cfg_valid, cfg_ready, cfg_index,  written when cfg_valid &
//            cfg_data                          cfg_ready (always ready)
//
// after reset both grids are swept to zero, one entry per cycle over all
// MAX_WIDTH*MAX_HEIGHT entries, with busy high; config writes are taken meanwhile.
// a write goes through S_WRITE and S_FINISH to done, a read through the front and
// back memory read ports, then the multiplier and the rounding adder.
// a step works on the W x H cells in use: one back read per cell for the copy,
// then eight front reads per cell through the single front read port into the
// shared accumulator, a state to finish the sum and one to write the cell back.
// done is a single-cycle strobe; the receiver cannot stall it.
module grid_neighbour_diffusion_step
    import gnd_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int CELL_BITS  = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  item_t                item,
    output logic                 done,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int EXTW_W = $clog2(MAX_WIDTH + 1);
    localparam int EXTH_W = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CFGW_W = (CFG_W > EXTW_W) ? CFG_W : EXTW_W;
    localparam int CFGH_W = (CFG_W > EXTH_W) ? CFG_W : EXTH_W;
    localparam int CMPC_W = (COORD_W > EXTW_W) ? COORD_W : EXTW_W;
    localparam int CMPR_W = (COORD_W > EXTH_W) ? COORD_W : EXTH_W;
    localparam int VW     = (VALUE_W > CELL_BITS) ? VALUE_W : CELL_BITS;
    localparam logic [VW-1:0] CELL_MAX_V = VW'({CELL_BITS{1'b1}});

    // sequencer states
    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_WRITE    = 4'd2;
    localparam logic [3:0] S_RD_ADDR  = 4'd3;
    localparam logic [3:0] S_RD_DATA  = 4'd4;
    localparam logic [3:0] S_RD_SUM   = 4'd5;
    localparam logic [3:0] S_COPY     = 4'd6;
    localparam logic [3:0] S_GAP      = 4'd7;
    localparam logic [3:0] S_NB       = 4'd8;
    localparam logic [3:0] S_ACC_LAST = 4'd9;
    localparam logic [3:0] S_CELL_WR  = 4'd10;
    localparam logic [3:0] S_FINISH   = 4'd11;

    // neighbour offset codes
    localparam logic [1:0] OFF_DEC  = 2'd0;
    localparam logic [1:0] OFF_SAME = 2'd1;
    localparam logic [1:0] OFF_INC  = 2'd2;

    localparam logic [2:0] NB_LAST = 3'd7;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        cell_addr = ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c));
    endfunction

    // row offset of neighbour k, row-major around the cell
    function automatic logic [1:0] nb_row_off(input logic [2:0] k);
        logic [1:0] off;
        case (k)
            3'd0, 3'd1, 3'd2: off = OFF_DEC;
            3'd3, 3'd4:       off = OFF_SAME;
            default:          off = OFF_INC;
        endcase
        nb_row_off = off;
    endfunction

    // column offset of neighbour k
    function automatic logic [1:0] nb_col_off(input logic [2:0] k);
        logic [1:0] off;
        case (k)
            3'd0, 3'd3, 3'd5: off = OFF_DEC;
            3'd1, 3'd6:       off = OFF_SAME;
            default:          off = OFF_INC;
        endcase
        nb_col_off = off;
    endfunction

    logic [3:0]           state_reg, state_next;
    logic                 done_reg, done_next;
    logic [ROW_W-1:0]     r_cnt_reg, r_cnt_next;
    logic [COL_W-1:0]     c_cnt_reg, c_cnt_next;
    logic [2:0]           k_reg, k_next;
    logic [ADDR_W-1:0]    clr_reg, clr_next;
    logic                 copy_v_reg, copy_v_next;
    logic                 nb_v_reg, nb_v_next;
    logic [CFG_W-1:0]     grid_width_reg, grid_height_reg;
    logic                 sat_reg, sat_next;
    logic [VALUE_W-1:0]   read_value_reg, read_value_next;
    item_t                item_reg, item_next;
    logic [ADDR_W-1:0]    copy_addr_reg, copy_addr_next;

    logic [EXTW_W-1:0]    w_use;
    logic [EXTH_W-1:0]    h_use;
    logic                 in_grid;
    logic [ADDR_W-1:0]    item_addr;
    logic [ADDR_W-1:0]    cur_addr;
    logic                 last_col, last_row;
    logic [ROW_W:0]       nr_ext;
    logic [COL_W:0]       nc_ext;
    logic                 nb_ok;
    logic [ADDR_W-1:0]    nb_addr;
    logic [CELL_BITS-1:0] write_val;

    logic                 front_we, back_we;
    logic [ADDR_W-1:0]    front_waddr, back_waddr, front_raddr, back_raddr;
    logic [CELL_BITS-1:0] front_wdata, back_wdata, front_rdata, back_rdata;

    acc_ctl_t             acc_ctl;
    logic [CELL_BITS-1:0] acc_half;
    logic                 acc_sat;
    logic                 blend_load;
    logic [VALUE_W-1:0]   blend_value;

    // grid extents in use, clamped to 1..max
    always_comb
    begin
        if (grid_width_reg == '0)
        begin
            w_use = EXTW_W'(1);
        end
        else if (CFGW_W'(grid_width_reg) > CFGW_W'(MAX_WIDTH))
        begin
            w_use = EXTW_W'(MAX_WIDTH);
        end
        else
        begin
            w_use = EXTW_W'(grid_width_reg);
        end

        if (grid_height_reg == '0)
        begin
            h_use = EXTH_W'(1);
        end
        else if (CFGH_W'(grid_height_reg) > CFGH_W'(MAX_HEIGHT))
        begin
            h_use = EXTH_W'(MAX_HEIGHT);
        end
        else
        begin
            h_use = EXTH_W'(grid_height_reg);
        end
    end

    // addressed cell of a write or read command
    assign in_grid   = (CMPC_W'(item_reg.col) < CMPC_W'(w_use)) &&
                       (CMPR_W'(item_reg.row) < CMPR_W'(h_use));
    assign item_addr = cell_addr(ROW_W'(item_reg.row), COL_W'(item_reg.col));

    // write value clamped to the cell range
    assign write_val = (VW'(item_reg.value) > CELL_MAX_V) ? CELL_BITS'(CELL_MAX_V)
                                                          : CELL_BITS'(item_reg.value);

    // scan position of a step
    assign cur_addr = cell_addr(r_cnt_reg, c_cnt_reg);
    assign last_col = (EXTW_W'(c_cnt_reg) == (w_use - EXTW_W'(1)));
    assign last_row = (EXTH_W'(r_cnt_reg) == (h_use - EXTH_W'(1)));

    // neighbour coordinates; a step off the low edge wraps far out of range
    always_comb
    begin
        case (nb_row_off(k_reg))
            OFF_DEC: nr_ext = (ROW_W+1)'(r_cnt_reg) - (ROW_W+1)'(1);
            OFF_INC: nr_ext = (ROW_W+1)'(r_cnt_reg) + (ROW_W+1)'(1);
            default: nr_ext = (ROW_W+1)'(r_cnt_reg);
        endcase
        case (nb_col_off(k_reg))
            OFF_DEC: nc_ext = (COL_W+1)'(c_cnt_reg) - (COL_W+1)'(1);
            OFF_INC: nc_ext = (COL_W+1)'(c_cnt_reg) + (COL_W+1)'(1);
            default: nc_ext = (COL_W+1)'(c_cnt_reg);
        endcase
    end

    assign nb_ok   = (nr_ext < (ROW_W+1)'(h_use)) && (nc_ext < (COL_W+1)'(w_use));
    assign nb_addr = nb_ok ? cell_addr(nr_ext[ROW_W-1:0], nc_ext[COL_W-1:0]) : cur_addr;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        done_next       = 1'b0;
        r_cnt_next      = r_cnt_reg;
        c_cnt_next      = c_cnt_reg;
        k_next          = k_reg;
        clr_next        = clr_reg;
        copy_v_next     = 1'b0;
        nb_v_next       = 1'b0;
        sat_next        = sat_reg;
        read_value_next = read_value_reg;
        item_next       = item_reg;
        copy_addr_next  = copy_addr_reg;
        back_we         = 1'b0;
        back_waddr      = item_addr;
        back_wdata      = write_val;
        back_raddr      = item_addr;
        front_raddr     = item_addr;
        acc_ctl         = '0;
        blend_load      = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    item_next       = item;
                    sat_next        = 1'b0;
                    read_value_next = '0;
                    r_cnt_next      = '0;
                    c_cnt_next      = '0;
                    k_next          = '0;
                    unique case (item.op)
                        OP_WRITE: state_next = S_WRITE;
                        OP_READ:  state_next = S_RD_ADDR;
                        OP_STEP:  state_next = S_COPY;
                        default:  state_next = S_FINISH;
                    endcase
                end
            end
            S_WRITE:
            begin
                back_we    = in_grid;
                state_next = S_FINISH;
            end
            S_RD_ADDR:
            begin
                state_next = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                blend_load = 1'b1;
                state_next = S_RD_SUM;
            end
            S_RD_SUM:
            begin
                read_value_next = in_grid ? blend_value : '0;
                state_next      = S_FINISH;
            end
            S_COPY:
            begin
                back_raddr     = cur_addr;
                copy_v_next    = 1'b1;
                copy_addr_next = cur_addr;
                if (last_col)
                begin
                    c_cnt_next = '0;
                    r_cnt_next = r_cnt_reg + ROW_W'(1);
                    if (last_row)
                    begin
                        r_cnt_next = '0;
                        state_next = S_GAP;
                    end
                end
                else
                begin
                    c_cnt_next = c_cnt_reg + COL_W'(1);
                end
            end
            S_GAP:
            begin
                state_next = S_NB;
            end
            S_NB:
            begin
                front_raddr   = nb_addr;
                nb_v_next     = nb_ok;
                acc_ctl.clear = (k_reg == '0);
                acc_ctl.add   = nb_v_reg;
                k_next        = k_reg + 3'd1;
                if (k_reg == NB_LAST)
                begin
                    state_next = S_ACC_LAST;
                end
            end
            S_ACC_LAST:
            begin
                acc_ctl.add = nb_v_reg;
                state_next  = S_CELL_WR;
            end
            S_CELL_WR:
            begin
                back_we    = 1'b1;
                back_waddr = cur_addr;
                back_wdata = acc_half;
                sat_next   = sat_reg | acc_sat;
                state_next = S_NB;
                if (last_col)
                begin
                    c_cnt_next = '0;
                    r_cnt_next = r_cnt_reg + ROW_W'(1);
                    if (last_row)
                    begin
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    c_cnt_next = c_cnt_reg + COL_W'(1);
                end
            end
            S_FINISH:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // clearing sweep of the back grid
        if (state_reg == S_CLEAR)
        begin
            back_we    = 1'b1;
            back_waddr = clr_reg;
            back_wdata = '0;
        end
    end

    // front grid writes: zero sweep or copy from back in the cycle after its read
    always_comb
    begin
        front_we    = 1'b0;
        front_waddr = copy_addr_reg;
        front_wdata = back_rdata;
        if (state_reg == S_CLEAR)
        begin
            front_we    = 1'b1;
            front_waddr = clr_reg;
            front_wdata = '0;
        end
        else if (copy_v_reg)
        begin
            front_we = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            done_reg   <= 1'b0;
            r_cnt_reg  <= '0;
            c_cnt_reg  <= '0;
            k_reg      <= '0;
            clr_reg    <= '0;
            copy_v_reg <= 1'b0;
            nb_v_reg   <= 1'b0;
            sat_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            r_cnt_reg  <= r_cnt_next;
            c_cnt_reg  <= c_cnt_next;
            k_reg      <= k_next;
            clr_reg    <= clr_next;
            copy_v_reg <= copy_v_next;
            nb_v_reg   <= nb_v_next;
            sat_reg    <= sat_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_WIDTH_RESET;
            grid_height_reg <= GRID_HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        read_value_reg <= read_value_next;
        copy_addr_reg  <= copy_addr_next;
    end

    // grid memories
    gnd_ram #(
        .WIDTH (CELL_BITS),
        .DEPTH (DEPTH)
    ) u_front_ram (
        .clk   (clk),
        .we    (front_we),
        .waddr (front_waddr),
        .wdata (front_wdata),
        .raddr (front_raddr),
        .rdata (front_rdata)
    );

    gnd_ram #(
        .WIDTH (CELL_BITS),
        .DEPTH (DEPTH)
    ) u_back_ram (
        .clk   (clk),
        .we    (back_we),
        .waddr (back_waddr),
        .wdata (back_wdata),
        .raddr (back_raddr),
        .rdata (back_rdata)
    );

    // shared neighbour accumulator
    gnd_acc #(
        .CELL_BITS (CELL_BITS)
    ) u_acc (
        .clk      (clk),
        .ctl      (acc_ctl),
        .operand  (front_rdata),
        .half_sat (acc_half),
        .sat      (acc_sat)
    );

    // blended read datapath
    gnd_blend #(
        .CELL_BITS (CELL_BITS)
    ) u_blend (
        .clk     (clk),
        .load    (blend_load),
        .front_q (front_rdata),
        .back_q  (back_rdata),
        .blend   (item_reg.blend),
        .value   (blend_value)
    );

    // outputs
    assign busy                  = (state_reg != S_IDLE);
    assign done                  = done_reg;
    assign result.read_value     = read_value_reg;
    assign result.step_saturated = sat_reg;
    assign cfg_ready             = 1'b1;

endmodule

FILE: design/gnd_ram.sv
`timescale 1ns / 1ps
// generic single write port ram with registered read
module gnd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/gnd_acc.sv
`timescale 1ns / 1ps
// shared neighbour accumulator with halving and saturation
module gnd_acc
    import gnd_pkg::*;
#(
    parameter int CELL_BITS = 16
) (
    input  logic                 clk,
    input  acc_ctl_t             ctl,
    input  logic [CELL_BITS-1:0] operand,
    output logic [CELL_BITS-1:0] half_sat,
    output logic                 sat
);

    // eight neighbours need three extra bits
    localparam int SUM_W = CELL_BITS + 3;

    logic [SUM_W-1:0]     sum_reg;
    logic [SUM_W-1:0]     sum_next;
    logic [SUM_W-2:0]     half;

    // clear at the first neighbour, add one neighbour per cycle
    always_comb
    begin
        sum_next = sum_reg;
        if (ctl.clear)
        begin
            sum_next = '0;
        end
        else if (ctl.add)
        begin
            sum_next = sum_reg + SUM_W'(operand);
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    // truncating half, clamped to the cell maximum
    assign half     = sum_reg[SUM_W-1:1];
    assign sat      = |half[SUM_W-2:CELL_BITS];
    assign half_sat = sat ? {CELL_BITS{1'b1}} : half[CELL_BITS-1:0];

endmodule

FILE: design/gnd_blend.sv
`timescale 1ns / 1ps
// blended read arithmetic: front + blend/256 * (back - front), rounded and clamped
module gnd_blend
    import gnd_pkg::*;
#(
    parameter int CELL_BITS = 16
) (
    input  logic                 clk,
    input  logic                 load,
    input  logic [CELL_BITS-1:0] front_q,
    input  logic [CELL_BITS-1:0] back_q,
    input  logic [BLEND_W-1:0]   blend,
    output logic [VALUE_W-1:0]   value
);

    localparam int DIFF_W = CELL_BITS + 1;
    localparam int PROD_W = CELL_BITS + BLEND_W + 2;
    localparam int T_W    = CELL_BITS + BLEND_W + 3;
    localparam int V_W    = T_W - BLEND_SHIFT;
    localparam logic signed [T_W-1:0] ROUND = T_W'(1 << (BLEND_SHIFT - 1));

    logic signed [DIFF_W-1:0]  diff;
    logic signed [BLEND_W:0]   blend_s;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [CELL_BITS-1:0]      front_reg;
    logic signed [T_W-1:0]     f_ext;
    logic signed [T_W-1:0]     p_ext;
    logic signed [T_W-1:0]     t;
    logic [V_W-1:0]            v;
    logic [CELL_BITS-1:0]      clamped;

    // input side: difference and product, registered on load
    assign diff    = signed'({1'b0, back_q}) - signed'({1'b0, front_q});
    assign blend_s = signed'({1'b0, blend});
    assign prod    = blend_s * diff;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg  <= prod;
            front_reg <= front_q;
        end
    end

    // output side: add, round, scale down and clamp
    assign f_ext = T_W'(front_reg);
    assign p_ext = T_W'(prod_reg);
    assign t     = (f_ext <<< BLEND_SHIFT) + p_ext + ROUND;
    assign v     = t[T_W-1:BLEND_SHIFT];

    always_comb
    begin
        if (t[T_W-1])
        begin
            clamped = '0;
        end
        else if (|v[V_W-1:CELL_BITS])
        begin
            clamped = {CELL_BITS{1'b1}};
        end
        else
        begin
            clamped = v[CELL_BITS-1:0];
        end
    end

    assign value = VALUE_W'(clamped);

endmodule

FILE: design/gnd_checker.sv
`timescale 1ns / 1ps
// port-level checker for the grid diffusion block, bound to the top level
module gnd_checker
    import gnd_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    // a result beat never lands while a command is in progress
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // an accepted command always occupies the block the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but block not busy");

    // no command finishes in the cycle right after it is taken
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result one cycle after accept");

    // one command gives one beat, so strobes never run back to back
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back to back result beats");

    // a read result and a step flag never come from the same command
    a_fields_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.step_saturated) |-> (result.read_value == '0))
        else $error("read value on a step result");

endmodule

bind grid_neighbour_diffusion_step gnd_checker u_gnd_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// testbench for the grid diffusion block: directed and random commands against a scoreboard
module tb_top;
    import gnd_pkg::*;

    localparam int GRID_MAX    = 256;
    localparam int CELL_MAX    = 65535;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int PHASES      = 10;
    localparam int PHASE_BEATS = 80;

    // codes the package leaves unnamed
    localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd2;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    item_t                item;
    logic                 done;
    result_t              result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // shadow copy of both grids and the size registers
    logic [VALUE_W-1:0] front_cells [GRID_MAX*GRID_MAX];
    logic [VALUE_W-1:0] back_cells  [GRID_MAX*GRID_MAX];
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;

    result_t pending_results [$];
    result_t oldest_result;
    int      errors = 0;
    int      cycles = 0;

    grid_neighbour_diffusion_step dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // size register as the block uses it
    function automatic int extent(logic [CFG_W-1:0] size);
        if (size == 0)
            return 1;
        if (size > GRID_MAX)
            return GRID_MAX;
        return int'(size);
    endfunction

    // copy back to front, then half the in-bounds neighbour sum into back
    function automatic logic diffuse_grid();
        int   w;
        int   h;
        int   r;
        int   c;
        int   dr;
        int   dc;
        int   sum;
        logic sat;
        w   = extent(width_reg);
        h   = extent(height_reg);
        sat = 1'b0;
        for (r = 0; r < h; r++)
            for (c = 0; c < w; c++)
                front_cells[r*GRID_MAX + c] = back_cells[r*GRID_MAX + c];
        for (r = 0; r < h; r++)
        begin
            for (c = 0; c < w; c++)
            begin
                sum = 0;
                for (dr = -1; dr <= 1; dr++)
                    for (dc = -1; dc <= 1; dc++)
                        if ((dr != 0 || dc != 0) && r + dr >= 0 && c + dc >= 0 &&
                            r + dr < h && c + dc < w)
                            sum += front_cells[(r+dr)*GRID_MAX + c + dc];
                sum = sum >> 1;
                if (sum > CELL_MAX)
                begin
                    sum = CELL_MAX;
                    sat = 1'b1;
                end
                back_cells[r*GRID_MAX + c] = sum[VALUE_W-1:0];
            end
        end
        return sat;
    endfunction

    // front + blend/256 * (back - front), rounded and clamped
    function automatic logic [VALUE_W-1:0] blended_cell(int c, int r, logic [BLEND_W-1:0] blend);
        longint f;
        longint b;
        longint t;
        f = front_cells[r*GRID_MAX + c];
        b = back_cells[r*GRID_MAX + c];
        t = f * 256 + longint'(blend) * (b - f) + 128;
        if (t < 0)
            return '0;
        t = t >>> BLEND_SHIFT;
        if (t > CELL_MAX)
            return '1;
        return t[VALUE_W-1:0];
    endfunction

    // apply one command to the shadow state and return its result beat
    function automatic result_t predict_command(item_t it);
        result_t res;
        int      c;
        int      r;
        logic    in_grid;
        res     = '0;
        c       = int'(it.col);
        r       = int'(it.row);
        in_grid = (c < extent(width_reg)) && (r < extent(height_reg));
        case (it.op)
            OP_WRITE: if (in_grid) back_cells[r*GRID_MAX + c] = it.value;
            OP_READ:  if (in_grid) res.read_value = blended_cell(c, r, it.blend);
            OP_STEP:  res.step_saturated = diffuse_grid();
            default:  ;
        endcase
        return res;
    endfunction

    function automatic item_t make_item(logic [OP_W-1:0] op, logic [COORD_W-1:0] col,
                                        logic [COORD_W-1:0] row, logic [VALUE_W-1:0] value,
                                        logic [BLEND_W-1:0] blend);
        item_t it;
        it.op    = op;
        it.col   = col;
        it.row   = row;
        it.value = value;
        it.blend = blend;
        return it;
    endfunction

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("tb_top: mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    // drive one command beat, hold it until taken, then leave start low for the given gap
    task automatic send_command(item_t it, int gap);
        logic [63:0] noise;
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(predict_command(it));
        if (gap > 0)
        begin
            noise = {$urandom, $urandom};
            @(negedge clk);
            start <= 1'b0;
            item  <= noise[$bits(item_t)-1:0];
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // stop sending and wait for every result and for the block to go idle
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_GRID_WIDTH:  width_reg = data;
            CFG_GRID_HEIGHT: height_reg = data;
            default:         ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_grid(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        wait_idle();
        write_register(CFG_GRID_WIDTH, w);
        write_register(CFG_GRID_HEIGHT, h);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result beat", int'(result), 0);
            else
            begin
                oldest_result = pending_results.pop_front();
                if (result.read_value !== oldest_result.read_value)
                    report_mismatch("read_value", int'(result.read_value),
                                    int'(oldest_result.read_value));
                if (result.step_saturated !== oldest_result.step_saturated)
                    report_mismatch("step_saturated", int'(result.step_saturated),
                                    int'(oldest_result.step_saturated));
            end
        end
    end

    // cleared grids read as zero, unused op gives zero
    task automatic test_reset_state();
        wait_idle();
        send_command(make_item(OP_READ, 8'd0, 8'd0, 16'h0000, 9'd0), 0);
        send_command(make_item(OP_READ, 8'd199, 8'd199, 16'h0000, 9'd256), 1);
        send_command(make_item(OP_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 9'h1FF), 0);
    endtask

    // writes at the edge of the default grid, outside it, and blended reads
    task automatic test_write_read();
        send_command(make_item(OP_WRITE, 8'd199, 8'd199, 16'hFFFF, 9'd0), 0);
        send_command(make_item(OP_WRITE, 8'd200, 8'd5, 16'h1234, 9'd0), 2);
        send_command(make_item(OP_READ, 8'd200, 8'd5, 16'h0000, 9'd256), 0);
        send_command(make_item(OP_READ, 8'd199, 8'd199, 16'h0000, 9'd256), 0);
        send_command(make_item(OP_READ, 8'd199, 8'd199, 16'h0000, 9'h1FF), 3);
        send_command(make_item(OP_READ, 8'd199, 8'd199, 16'h0000, 9'd128), 0);
    endtask

    // a few steps on a 3x3 grid, ending in saturation; extrapolating reads
    task automatic test_step_small();
        set_grid(9'd3, 9'd3);
        send_command(make_item(OP_WRITE, 8'd0, 8'd0, 16'hFFFF, 9'd0), 0);
        send_command(make_item(OP_WRITE, 8'd1, 8'd1, 16'h8000, 9'd0), 0);
        send_command(make_item(OP_WRITE, 8'd2, 8'd2, 16'h0001, 9'd0), 1);
        send_command(make_item(OP_STEP, 8'd0, 8'd0, 16'h0000, 9'd0), 0);
        send_command(make_item(OP_READ, 8'd0, 8'd0, 16'h0000, 9'h1FF), 0);
        send_command(make_item(OP_READ, 8'd1, 8'd1, 16'h0000, 9'd128), 4);
        send_command(make_item(OP_STEP, 8'd0, 8'd0, 16'h0000, 9'd0), 0);
        send_command(make_item(OP_STEP, 8'd0, 8'd0, 16'h0000, 9'd0), 0);
    endtask

    // zero size means one cell, oversize clamps to the maximum, unused register index
    task automatic test_size_extremes();
        set_grid(9'd0, 9'd0);
        send_command(make_item(OP_WRITE, 8'd0, 8'd0, 16'h5555, 9'd0), 0);
        send_command(make_item(OP_WRITE, 8'd1, 8'd0, 16'hFFFF, 9'd0), 0);
        send_command(make_item(OP_STEP, 8'd0, 8'd0, 16'h0000, 9'd0), 0);
        send_command(make_item(OP_READ, 8'd0, 8'd0, 16'h0000, 9'd256), 0);
        set_grid(9'h1FF, 9'd256);
        send_command(make_item(OP_WRITE, 8'hFF, 8'hFF, 16'hAAAA, 9'd0), 0);
        send_command(make_item(OP_WRITE, 8'hAA, 8'h55, 16'h5555, 9'd0), 0);
        send_command(make_item(OP_READ, 8'hFF, 8'hFF, 16'h0000, 9'd256), 0);
        send_command(make_item(OP_READ, 8'hAA, 8'h55, 16'h0000, 9'h155), 0);
        set_grid(9'd256, 9'd1);
        write_register(CFG_UNUSED, 9'h0AA);
        send_command(make_item(OP_STEP, 8'd0, 8'd0, 16'h0000, 9'd0), 0);
        send_command(make_item(OP_READ, 8'hAA, 8'd0, 16'h0000, 9'd256), 0);
    endtask

    // random commands over a series of grid sizes
    task automatic test_random();
        int                 phase;
        int                 n;
        int                 roll;
        int                 wext;
        int                 hext;
        logic               steps_on;
        logic               no_gaps;
        logic [CFG_W-1:0]   w;
        logic [CFG_W-1:0]   h;
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [VALUE_W-1:0] value;
        logic [BLEND_W-1:0] blend;
        for (phase = 0; phase < PHASES; phase++)
        begin
            steps_on = 1'b1;
            // wide or tall grids stay thin in the other direction so steps stay short
            case (phase % 5)
                0:
                begin
                    w = CFG_W'($urandom_range(2, 10));
                    h = CFG_W'($urandom_range(2, 10));
                end
                1:
                begin
                    w = CFG_W'($urandom_range(0, 1));
                    h = CFG_W'($urandom_range(1, 12));
                end
                2:
                begin
                    w = CFG_W'($urandom_range(256, 511));
                    h = CFG_W'($urandom_range(1, 2));
                end
                3:
                begin
                    w = CFG_W'($urandom_range(1, 2));
                    h = CFG_W'($urandom_range(256, 511));
                end
                default:
                begin
                    w        = CFG_W'($urandom_range(128, 511));
                    h        = CFG_W'($urandom_range(128, 511));
                    steps_on = 1'b0;
                end
            endcase
            set_grid(w, h);
            wext    = extent(w);
            hext    = extent(h);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (n = 0; n < PHASE_BEATS; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 45)
                    op = OP_WRITE;
                else if (roll < 85 || (roll < 95 && !steps_on))
                    op = OP_READ;
                else if (roll < 95)
                    op = OP_STEP;
                else
                    op = OP_UNUSED;
                // mostly inside the grid in use, sometimes anywhere
                col = ($urandom_range(0, 6) == 0) ? COORD_W'($urandom_range(0, 255))
                                                  : COORD_W'($urandom_range(0, wext - 1));
                row = ($urandom_range(0, 6) == 0) ? COORD_W'($urandom_range(0, 255))
                                                  : COORD_W'($urandom_range(0, hext - 1));
                case ($urandom_range(0, 3))
                    0:       value = VALUE_W'($urandom_range(0, 15));
                    1:       value = VALUE_W'($urandom_range(CELL_MAX - 15, CELL_MAX));
                    default: value = VALUE_W'($urandom_range(0, CELL_MAX));
                endcase
                blend = ($urandom_range(0, 3) == 0) ? BLEND_W'($urandom_range(0, 511))
                                                    : BLEND_W'($urandom_range(0, 256));
                send_command(make_item(op, col, row, value, blend), no_gaps ? 0 : pick_gap());
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        width_reg  = GRID_WIDTH_RESET;
        height_reg = GRID_HEIGHT_RESET;
        for (int i = 0; i < GRID_MAX*GRID_MAX; i++)
        begin
            front_cells[i] = '0;
            back_cells[i]  = '0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_write_read();
        test_step_small();
        test_size_extremes();
        test_random();

        // let every result arrive, then watch for stray beats
        wait_idle();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

FILE: files.f
design/gnd_pkg.sv
design/gnd_ram.sv
design/gnd_acc.sv
design/gnd_blend.sv
design/grid_neighbour_diffusion_step.sv
design/gnd_checker.sv
sim/tb_top.sv
